@@ rtl/core/hrhp_pkg.sv @@
// Package for the HTTP request head parser: parse states, codes, register indices, limits.
// No dependencies.
`default_nettype none
package hrhp_pkg;
	localparam int METHOD_BYTES = 7;
	localparam int LENGTH_BITS  = 16;

	typedef enum logic [4:0] {
		S_METHOD_START, S_METHOD, S_URI_START, S_URI, S_H, S_T1, S_T2, S_P,
		S_SLASH, S_MAJOR_START, S_MAJOR, S_MINOR_START, S_MINOR, S_NL1,
		S_LINE_START, S_LWS, S_NAME, S_SPACE, S_VALUE, S_NL2, S_NL3
	} parse_state_t;

	typedef enum logic [1:0] {ST_MORE = 2'd0, ST_DONE = 2'd1, ST_REJECT = 2'd2} status_t;
	typedef enum logic [1:0] {
		K_NONE = 2'd0, K_URI = 2'd1, K_NAME = 2'd2, K_VALUE = 2'd3
	} kind_t;

	localparam logic [2:0] REG_ALLOW_CONNECT = 3'd0;
	localparam logic [2:0] REG_METHOD_LIMIT  = 3'd1;
	localparam logic [2:0] REG_NAME_LIMIT    = 3'd2;
	localparam logic [2:0] REG_LONG_LIMIT    = 3'd3;
	localparam logic [2:0] REG_COOKIE_LIMIT  = 3'd4;
	localparam logic [2:0] REG_COUNT_LIMIT   = 3'd5;
	localparam logic [2:0] REG_VERSION_LIMIT = 3'd6;

	localparam logic [2:0] M_CONNECT = 3'd7;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	function automatic logic is_token(input logic [7:0] c);
		logic r;
		r = (c >= 8'h21) && (c <= 8'h7E);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
			"=", "{", "}": r = 1'b0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// Cookie name letter at position p (0..5)
	function automatic logic [7:0] cookie_char(input logic [2:0] p);
		logic [7:0] r;
		case (p)
			3'd0: r = "C";
			3'd1, 3'd2: r = "o";
			3'd3: r = "k";
			3'd4: r = "i";
			3'd5: r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/http_request_head_parser.sv @@
// HTTP request head parser top level: input register, parse logic, result register.
// Depends on hrhp_pkg.
`default_nettype none
// One byte of the request stream is one beat on the input channel, and each byte
// gives exactly one result beat. The parse step for a byte is combinational
// between the input register and the result register, so one byte per clock
// is sustained while the result is not stalled. While a result beat is stalled,
// one more byte can still enter the input register; after that the input stalls
// until the result is taken. A byte passes through the input register and then
// the result register, where its result beat is valid. Configuration writes
// should only be issued while no bytes are in flight. After a complete or a
// rejected head the parse state returns to method start.
module http_request_head_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  status,
	output      logic [1:0]  byte_kind,
	output      logic [7:0]  out_byte,
	output      logic        new_header,
	output      logic [7:0]  header_index,
	output      logic [2:0]  method_code,
	output      logic [15:0] version_major,
	output      logic [15:0] version_minor,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import hrhp_pkg::*;

	// config registers
	logic        allow_connect_q;
	logic [4:0]  method_limit_q;
	logic [15:0] name_limit_q, long_limit_q, cookie_limit_q, version_limit_q;
	logic [7:0]  count_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_connect_q <= 1'b0;
			method_limit_q  <= 5'd8;
			name_limit_q    <= 16'd256;
			long_limit_q    <= 16'd4096;
			cookie_limit_q  <= 16'd16384;
			count_limit_q   <= 8'd64;
			version_limit_q <= 16'd999;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALLOW_CONNECT: allow_connect_q <= cfg_data[0];
				REG_METHOD_LIMIT:  method_limit_q  <= cfg_data[4:0];
				REG_NAME_LIMIT:    name_limit_q    <= cfg_data;
				REG_LONG_LIMIT:    long_limit_q    <= cfg_data;
				REG_COOKIE_LIMIT:  cookie_limit_q  <= cfg_data;
				REG_COUNT_LIMIT:   count_limit_q   <= cfg_data[7:0];
				REG_VERSION_LIMIT: version_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register. Moves when stage 2 can take it.
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       v_s2;
	logic       adv_s2;
	assign adv_s2   = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (!in_stall) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) byte_s1 <= data_byte;
	end

	// parse state
	parse_state_t st_q, st_d;
	logic [7:0]  mchars_q [METHOD_BYTES];
	logic [7:0]  mchars_d [METHOD_BYTES];
	logic [4:0]  mlen_q, mlen_d;
	logic [2:0]  mfound_q, mfound_d;
	logic [LENGTH_BITS-1:0] flen_q, flen_d;
	logic [7:0]  htot_q, htot_d;
	logic [2:0]  cprog_q, cprog_d;
	logic        cookie_q, cookie_d;
	logic [15:0] major_q, major_d, minor_q, minor_d;

	logic [7:0]  c;
	logic        ok;
	logic [1:0]  stat_c, kind_c;
	logic        nh_c;
	logic [15:0] dig_base;
	logic [LENGTH_BITS-1:0] flen_inc;
	logic        full;
	logic [2:0]  m;
	logic        mhit;
	logic [15:0] vlimit;

	assign c        = byte_s1;
	assign full     = (flen_q == LEN_MAX);
	assign flen_inc = flen_q + 1'b1;
	assign dig_base = (st_q == S_MAJOR) ? major_q : minor_q;
	assign vlimit   = cookie_q ? cookie_limit_q : long_limit_q;

	// method matcher: compare the kept characters against the eight names
	always_comb begin
		logic [7:0] a0, a1, a2, a3, a4, a5, a6;
		a0 = mchars_q[0]; a1 = mchars_q[1]; a2 = mchars_q[2]; a3 = mchars_q[3];
		a4 = mchars_q[4]; a5 = mchars_q[5]; a6 = mchars_q[6];
		mhit = 1'b1;
		m    = 3'd0;
		if (mlen_q == 5'd3 && a0 == "G" && a1 == "E" && a2 == "T") m = 3'd0;
		else if (mlen_q == 5'd4 && a0 == "P" && a1 == "O" && a2 == "S" && a3 == "T")
			m = 3'd1;
		else if (mlen_q == 5'd4 && a0 == "H" && a1 == "E" && a2 == "A" && a3 == "D")
			m = 3'd2;
		else if (mlen_q == 5'd3 && a0 == "P" && a1 == "U" && a2 == "T") m = 3'd3;
		else if (mlen_q == 5'd6 && a0 == "D" && a1 == "E" && a2 == "L" && a3 == "E"
			&& a4 == "T" && a5 == "E") m = 3'd4;
		else if (mlen_q == 5'd5 && a0 == "T" && a1 == "R" && a2 == "A" && a3 == "C"
			&& a4 == "E") m = 3'd5;
		else if (mlen_q == 5'd7 && a0 == "O" && a1 == "P" && a2 == "T" && a3 == "I"
			&& a4 == "O" && a5 == "N" && a6 == "S") m = 3'd6;
		else if (mlen_q == 5'd7 && a0 == "C" && a1 == "O" && a2 == "N" && a3 == "N"
			&& a4 == "E" && a5 == "C" && a6 == "T") m = M_CONNECT;
		else mhit = 1'b0;
	end

	always_comb begin
		logic [19:0] nv;
		logic [5:0]  mnext;
		// next version number: value * 10 + digit, by shift and add
		nv = ({4'd0, dig_base} << 3) + ({4'd0, dig_base} << 1) + {16'd0, c[3:0]};
		mnext = {1'b0, mlen_q} + 6'd1;
		st_d = st_q;
		mchars_d = mchars_q;
		mlen_d = mlen_q; mfound_d = mfound_q; flen_d = flen_q; htot_d = htot_q;
		cprog_d = cprog_q; cookie_d = cookie_q; major_d = major_q; minor_d = minor_q;
		ok = 1'b1; stat_c = ST_MORE; kind_c = K_NONE; nh_c = 1'b0;
		unique case (st_q)
			S_METHOD_START: begin
				if (!is_token(c)) ok = 1'b0;
				else begin
					for (int i = 0; i < METHOD_BYTES; i++) mchars_d[i] = 8'd0;
					mchars_d[0] = upper(c);
					mlen_d = 5'd1;
					st_d = S_METHOD;
				end
			end
			S_METHOD: begin
				if (c == " ") begin
					if (!mhit || (m == M_CONNECT && !allow_connect_q)) ok = 1'b0;
					else begin
						mfound_d = m;
						st_d = S_URI_START;
					end
				end else if (!is_token(c) || mnext > 6'd31 || mnext > {1'b0, method_limit_q})
					ok = 1'b0;
				else begin
					for (int i = 0; i < METHOD_BYTES; i++)
						if (mlen_q == 5'(i)) mchars_d[i] = upper(c);
					mlen_d = mnext[4:0];
				end
			end
			S_URI_START: begin
				if (c < 8'h21 || c > 8'h7E) ok = 1'b0;
				else begin
					flen_d = LENGTH_BITS'(1);
					kind_c = K_URI;
					st_d = S_URI;
				end
			end
			S_URI: begin
				if (c == " ") st_d = S_H;
				else if (c >= 8'h21 && c <= 8'h7E && !full && flen_inc <= long_limit_q) begin
					flen_d = flen_inc;
					kind_c = K_URI;
				end else ok = 1'b0;
			end
			S_H:  if (c == "H") st_d = S_T1; else ok = 1'b0;
			S_T1: if (c == "T") st_d = S_T2; else ok = 1'b0;
			S_T2: if (c == "T") st_d = S_P; else ok = 1'b0;
			S_P:  if (c == "P") st_d = S_SLASH; else ok = 1'b0;
			S_SLASH: begin
				if (c != "/") ok = 1'b0;
				else begin
					major_d = 16'd0; minor_d = 16'd0;
					st_d = S_MAJOR_START;
				end
			end
			S_MAJOR_START: begin
				if (c < "0" || c > "9") ok = 1'b0;
				else begin
					major_d = {12'd0, c[3:0]};
					st_d = S_MAJOR;
				end
			end
			S_MAJOR: begin
				if (c == ".") st_d = S_MINOR_START;
				else if (c < "0" || c > "9" || nv > {4'd0, version_limit_q}) ok = 1'b0;
				else major_d = nv[15:0];
			end
			S_MINOR_START: begin
				if (c < "0" || c > "9") ok = 1'b0;
				else begin
					minor_d = {12'd0, c[3:0]};
					st_d = S_MINOR;
				end
			end
			S_MINOR: begin
				if (c == 8'h0D) st_d = S_NL1;
				else if (c < "0" || c > "9" || nv > {4'd0, version_limit_q}) ok = 1'b0;
				else minor_d = nv[15:0];
			end
			S_NL1: if (c == 8'h0A) st_d = S_LINE_START; else ok = 1'b0;
			S_LINE_START: begin
				if (c == 8'h0D) st_d = S_NL3;
				else if (htot_q != 8'd0 && (c == " " || c == 8'h09)) st_d = S_LWS;
				else if (!is_token(c) || ({1'b0, htot_q} + 9'd1) > {1'b0, count_limit_q})
					ok = 1'b0;
				else begin
					htot_d = htot_q + 8'd1;
					flen_d = LENGTH_BITS'(1);
					cprog_d = (c == "C") ? 3'd1 : 3'd0;
					cookie_d = 1'b0;
					kind_c = K_NAME;
					nh_c = 1'b1;
					st_d = S_NAME;
				end
			end
			S_LWS: begin
				if (c == 8'h0D) st_d = S_NL2;
				else if (c == " " || c == 8'h09) ;
				else if (c < 8'h20 || c == 8'h7F || full) ok = 1'b0;
				else begin
					flen_d = flen_inc;
					kind_c = K_VALUE;
					st_d = S_VALUE;
				end
			end
			S_NAME: begin
				if (c == ":") begin
					cookie_d = (cprog_q == 3'd6) && (flen_q == LENGTH_BITS'(6));
					st_d = S_SPACE;
				end else if (!is_token(c) || full || flen_inc > name_limit_q) ok = 1'b0;
				else begin
					flen_d = flen_inc;
					if (flen_q < LENGTH_BITS'(6) && {{(LENGTH_BITS-3){1'b0}}, cprog_q} == flen_q
						&& c == cookie_char(cprog_q))
						cprog_d = cprog_q + 3'd1;
					kind_c = K_NAME;
				end
			end
			S_SPACE: begin
				if (c != " ") ok = 1'b0;
				else begin
					flen_d = '0;
					st_d = S_VALUE;
				end
			end
			S_VALUE: begin
				if (c == 8'h0D) st_d = S_NL2;
				else if (c < 8'h20 || c == 8'h7F || full || flen_inc > vlimit) ok = 1'b0;
				else begin
					flen_d = flen_inc;
					kind_c = K_VALUE;
				end
			end
			S_NL2: if (c == 8'h0A) st_d = S_LINE_START; else ok = 1'b0;
			S_NL3: if (c == 8'h0A) stat_c = ST_DONE; else ok = 1'b0;
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			stat_c = ST_REJECT; kind_c = K_NONE; nh_c = 1'b0;
		end
	end

	logic clear;
	assign clear = (stat_c != ST_MORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_METHOD_START;
			mlen_q <= '0; mfound_q <= '0; flen_q <= '0; htot_q <= '0;
			cprog_q <= '0; cookie_q <= 1'b0; major_q <= '0; minor_q <= '0;
		end else if (adv_s2) begin
			if (clear) begin
				st_q <= S_METHOD_START;
				mlen_q <= '0; mfound_q <= '0; flen_q <= '0; htot_q <= '0;
				cprog_q <= '0; cookie_q <= 1'b0; major_q <= '0; minor_q <= '0;
			end else begin
				st_q <= st_d;
				mlen_q <= mlen_d; mfound_q <= mfound_d; flen_q <= flen_d; htot_q <= htot_d;
				cprog_q <= cprog_d; cookie_q <= cookie_d; major_q <= major_d;
				minor_q <= minor_d;
			end
		end
	end

	// method characters are always overwritten at method start, no reset needed
	always_ff @(posedge clk) begin
		if (adv_s2) mchars_q <= mchars_d;
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv_s2) v_s2 <= 1'b1;
		else if (!out_stall) v_s2 <= 1'b0;
	end

	logic [1:0]  stat_s2, kind_s2;
	logic [7:0]  byte_s2, hidx_s2;
	logic        nh_s2;
	logic [2:0]  mcode_s2;
	logic [15:0] maj_s2, min_s2;

	// state fields show the state after this byte, before any return to method start;
	// a rejecting byte leaves them unchanged
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			stat_s2  <= stat_c;
			kind_s2  <= kind_c;
			byte_s2  <= (kind_c != K_NONE) ? c : 8'd0;
			nh_s2    <= nh_c;
			hidx_s2  <= (htot_d == 8'd0) ? 8'd0 : htot_d - 8'd1;
			mcode_s2 <= mfound_d;
			maj_s2   <= major_d;
			min_s2   <= minor_d;
		end
	end

	assign out_valid     = v_s2;
	assign status        = stat_s2;
	assign byte_kind     = kind_s2;
	assign out_byte      = byte_s2;
	assign new_header    = nh_s2;
	assign header_index  = hidx_s2;
	assign method_code   = mcode_s2;
	assign version_major = maj_s2;
	assign version_minor = min_s2;
endmodule
`default_nettype wire

@@ verif/http_request_head_parser_tb.sv @@
// Self-checking testbench for http_request_head_parser: byte stream in, one result per byte.
// Depends on hrhp_pkg and the parser RTL; a parse model in this file predicts every result.
`default_nettype none
module http_request_head_parser_tb;
	import hrhp_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  byte_kind;
		logic [7:0]  out_byte;
		logic        new_header;
		logic [7:0]  header_index;
		logic [2:0]  method_code;
		logic [15:0] version_major;
		logic [15:0] version_minor;
	} parse_result_t;

	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [1:0]  byte_kind;
	logic [7:0]  out_byte;
	logic        new_header;
	logic [7:0]  header_index;
	logic [2:0]  method_code;
	logic [15:0] version_major;
	logic [15:0] version_minor;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	http_request_head_parser dut (.*);

	// Predictor copy of the parser registers and parse state
	logic        p_allow_connect;
	logic [4:0]  p_method_limit;
	logic [15:0] p_name_limit, p_long_limit, p_cookie_limit, p_version_limit;
	logic [7:0]  p_count_limit;

	parse_state_t pst;
	logic [7:0]  mchars [METHOD_BYTES];
	int unsigned mlen, mfound, flen, htotal, cprog, vmaj, vmin;
	logic        is_cookie;

	// Stimulus and expectation stores
	logic [7:0]    byte_queue[$];
	int            hold_queue[$];       // marker: -1 means wait until drained
	parse_result_t result_queue[$];

	int  errors = 0;
	int  cycles = 0;
	bit  hold_req = 0;            // asks the receiver for one long hold-off

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bit tok(logic [7:0] c);
		if (c < 8'h21 || c > 8'h7E) return 0;
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
			"=", "{", "}": return 0;
			default: return 1;
		endcase
	endfunction

	function automatic bit ctl(logic [7:0] c);
		return c < 8'h20 || c == 8'h7F;
	endfunction

	function automatic logic [7:0] upcase(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	task automatic clear_parse();
		pst = S_METHOD_START;
		foreach (mchars[i]) mchars[i] = 0;
		mlen = 0; mfound = 0; flen = 0; htotal = 0; cprog = 0;
		is_cookie = 0; vmaj = 0; vmin = 0;
	endtask

	// Bumps the field length; 0 when the counter or the limit is passed
	function automatic bit grow_len(int unsigned lim, bit chk);
		if (flen >= 65535) return 0;
		flen++;
		return !chk || flen <= lim;
	endfunction

	function automatic bit add_dig(inout int unsigned v, input logic [7:0] c);
		int unsigned n;
		n = v * 10 + (c - "0");
		if (n > p_version_limit) return 0;
		v = n;
		return 1;
	endfunction

	function automatic int match_method();
		string names [8];
		bit hit;
		names = '{"GET", "POST", "HEAD", "PUT", "DELETE", "TRACE", "OPTIONS", "CONNECT"};
		for (int k = 0; k < 8; k++) begin
			if (mlen != names[k].len() || mlen > METHOD_BYTES) continue;
			hit = 1;
			for (int i = 0; i < mlen; i++)
				if (mchars[i] != names[k][i]) hit = 0;
			if (hit) return k;
		end
		return -1;
	endfunction

	task automatic predict_byte(input logic [7:0] c);
		parse_result_t r;
		bit ok;
		int m;
		logic [1:0] kind;
		logic st, nh;
		int unsigned pos;
		ok = 1; kind = K_NONE; st = 0; nh = 0;
		case (pst)
			S_METHOD_START:
				if (!tok(c)) ok = 0;
				else begin
					foreach (mchars[i]) mchars[i] = 0;
					mchars[0] = upcase(c);
					mlen = 1;
					pst = S_METHOD;
				end
			S_METHOD:
				if (c == " ") begin
					m = match_method();
					if (m < 0 || (m == M_CONNECT && !p_allow_connect)) ok = 0;
					else begin
						mfound = m;
						pst = S_URI_START;
					end
				end else if (!tok(c) || mlen + 1 > 31 || mlen + 1 > p_method_limit) ok = 0;
				else begin
					if (mlen < METHOD_BYTES) mchars[mlen] = upcase(c);
					mlen++;
				end
			S_URI_START:
				if (c < 8'h21 || c > 8'h7E) ok = 0;
				else begin
					flen = 1; kind = K_URI; pst = S_URI;
				end
			S_URI:
				if (c == " ") pst = S_H;
				else if (c >= 8'h21 && c <= 8'h7E && grow_len(p_long_limit, 1)) kind = K_URI;
				else ok = 0;
			S_H:  if (c == "H") pst = S_T1; else ok = 0;
			S_T1: if (c == "T") pst = S_T2; else ok = 0;
			S_T2: if (c == "T") pst = S_P; else ok = 0;
			S_P:  if (c == "P") pst = S_SLASH; else ok = 0;
			S_SLASH:
				if (c != "/") ok = 0;
				else begin
					vmaj = 0; vmin = 0; pst = S_MAJOR_START;
				end
			S_MAJOR_START:
				if (c < "0" || c > "9") ok = 0;
				else begin
					vmaj = c - "0"; pst = S_MAJOR;
				end
			S_MAJOR:
				if (c == ".") pst = S_MINOR_START;
				else if (c < "0" || c > "9" || !add_dig(vmaj, c)) ok = 0;
			S_MINOR_START:
				if (c < "0" || c > "9") ok = 0;
				else begin
					vmin = c - "0"; pst = S_MINOR;
				end
			S_MINOR:
				if (c == 8'h0D) pst = S_NL1;
				else if (c < "0" || c > "9" || !add_dig(vmin, c)) ok = 0;
			S_NL1: if (c == 8'h0A) pst = S_LINE_START; else ok = 0;
			S_LINE_START:
				if (c == 8'h0D) pst = S_NL3;
				else if (htotal != 0 && (c == " " || c == 8'h09)) pst = S_LWS;
				else if (!tok(c) || htotal + 1 > p_count_limit) ok = 0;
				else begin
					htotal++;
					flen = 1;
					cprog = (c == "C") ? 1 : 0;
					is_cookie = 0;
					kind = K_NAME; nh = 1;
					pst = S_NAME;
				end
			S_LWS:
				if (c == 8'h0D) pst = S_NL2;
				else if (c == " " || c == 8'h09) ;
				else if (ctl(c) || !grow_len(0, 0)) ok = 0;
				else begin
					kind = K_VALUE; pst = S_VALUE;
				end
			S_NAME:
				if (c == ":") begin
					is_cookie = (cprog == 6 && flen == 6);
					pst = S_SPACE;
				end else if (!tok(c)) ok = 0;
				else begin
					pos = flen;
					if (!grow_len(p_name_limit, 1)) ok = 0;
					else begin
						if (pos < 6 && cprog == pos && c == cookie_char(pos[2:0])) cprog++;
						kind = K_NAME;
					end
				end
			S_SPACE:
				if (c != " ") ok = 0;
				else begin
					flen = 0; pst = S_VALUE;
				end
			S_VALUE:
				if (c == 8'h0D) pst = S_NL2;
				else if (ctl(c) || !grow_len(is_cookie ? p_cookie_limit : p_long_limit, 1))
					ok = 0;
				else kind = K_VALUE;
			S_NL2: if (c == 8'h0A) pst = S_LINE_START; else ok = 0;
			S_NL3: if (c == 8'h0A) st = 1; else ok = 0;
			default: ok = 0;
		endcase
		r.status = ok ? (st ? ST_DONE : ST_MORE) : ST_REJECT;
		if (!ok) begin
			kind = K_NONE; nh = 0;
		end
		r.byte_kind = kind;
		r.out_byte = (kind != K_NONE) ? c : 8'h00;
		r.new_header = nh;
		r.header_index = htotal ? 8'(htotal - 1) : 8'h00;
		r.method_code = 3'(mfound);
		r.version_major = 16'(vmaj);
		r.version_minor = 16'(vmin);
		result_queue = {result_queue, r};
		if (r.status != ST_MORE) clear_parse();
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ALLOW_CONNECT: p_allow_connect = val[0];
			REG_METHOD_LIMIT:  p_method_limit = val[4:0];
			REG_NAME_LIMIT:    p_name_limit = val;
			REG_LONG_LIMIT:    p_long_limit = val;
			REG_COOKIE_LIMIT:  p_cookie_limit = val;
			REG_COUNT_LIMIT:   p_count_limit = val[7:0];
			REG_VERSION_LIMIT: p_version_limit = val;
			default: ;
		endcase
	endtask

	// Driver: one byte per beat, random gap before each, drains at markers
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			data_byte <= 0;
			gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(data_byte);
				void'(byte_queue.pop_front());
				void'(hold_queue.pop_front());
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 2) == 0) gap = 0;
			end
			if (!in_valid || !in_stall) begin
				if (byte_queue.size() == 0) in_valid <= 0;
				else if (hold_queue[0] < 0 && result_queue.size() != 0) in_valid <= 0;
				else if (gap > 0) begin
					gap--;
					in_valid <= 0;
				end else begin
					if (hold_queue[0] < 0) hold_queue[0] = 0;
					in_valid <= 1;
					data_byte <= byte_queue[0];
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction
	int stall_left = 0;
	int rx_hold = 0;              // long receiver hold-off, in cycles
	bit hold_taken = 0;
	always @(posedge clk or negedge arst_n) begin
		parse_result_t got, want;
		if (!arst_n) begin
			out_stall <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{status, byte_kind, out_byte, new_header, header_index,
					method_code, version_major, version_minor};
				if (result_queue.size() == 0) begin
					$display("%0t unexpected result %h", $time, got);
					errors++;
				end else begin
					want = result_queue.pop_front();
					if (got.status != want.status)
						$display("%0t status exp %0d got %0d", $time, want.status, got.status);
					if (got.byte_kind != want.byte_kind)
						$display("%0t byte_kind exp %0d got %0d", $time, want.byte_kind,
							got.byte_kind);
					if (got.out_byte != want.out_byte)
						$display("%0t out_byte exp %h got %h", $time, want.out_byte,
							got.out_byte);
					if (got.new_header != want.new_header)
						$display("%0t new_header exp %0d got %0d", $time, want.new_header,
							got.new_header);
					if (got.header_index != want.header_index)
						$display("%0t header_index exp %0d got %0d", $time,
							want.header_index, got.header_index);
					if (got.method_code != want.method_code)
						$display("%0t method_code exp %0d got %0d", $time,
							want.method_code, got.method_code);
					if (got.version_major != want.version_major)
						$display("%0t version_major exp %0d got %0d", $time,
							want.version_major, got.version_major);
					if (got.version_minor != want.version_minor)
						$display("%0t version_minor exp %0d got %0d", $time,
							want.version_minor, got.version_minor);
					if (got != want) errors++;
				end
				stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				rx_hold = 200;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1;
			end else out_stall <= 0;
		end
	end

	// Queues a string of bytes; a leading drain marks a pause until idle
	task automatic push_str(input string s, input bit drain_first = 0);
		for (int i = 0; i < s.len(); i++) begin
			byte_queue = {byte_queue, s[i]};
			hold_queue = {hold_queue, ((i == 0 && drain_first) ? -1 : 0)};
		end
	endtask

	function automatic string rnd_tok(int n);
		string s, pool;
		pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-.^_|~";
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
		return s;
	endfunction

	function automatic string rnd_text(int n, logic [7:0] lo);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(lo, 8'h7E)))};
		return s;
	endfunction

	// A mostly well-formed request with random content and rare damage
	function automatic string rnd_request();
		string meths [9], s;
		int nh;
		meths = '{"GET", "post", "Head", "PUT", "DELETE", "TRACE", "OPTIONS", "CONNECT",
			"PATCH"};
		s = {meths[$urandom_range(0, 8)], " /", rnd_text($urandom_range(0, 6), 8'h21),
			" HTTP/", $sformatf("%0d.%0d", $urandom_range(0, 12), $urandom_range(0, 1200)),
			"\r\n"};
		nh = $urandom_range(0, 4);
		for (int h = 0; h < nh; h++) begin
			if ($urandom_range(0, 3) == 0) s = {s, "Cookie: ", rnd_text($urandom_range(0, 8),
				8'h20), "\r\n"};
			else s = {s, rnd_tok($urandom_range(1, 6)), ": ", rnd_text($urandom_range(0, 8),
				8'h20), "\r\n"};
			if ($urandom_range(0, 5) == 0) s = {s, " \t", rnd_text($urandom_range(0, 4), 8'h21),
				"\r\n"};
		end
		s = {s, "\r\n"};
		if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
		return s;
	endfunction

	task automatic wait_idle();
		while (byte_queue.size() != 0 || result_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		string noise;
		arst_n = 0;
		cfg_we = 0; cfg_index = REG_ALLOW_CONNECT; cfg_data = 0;
		p_allow_connect = 0; p_method_limit = 8; p_name_limit = 256; p_long_limit = 4096;
		p_cookie_limit = 16384; p_count_limit = 64; p_version_limit = 999;
		clear_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// Directed: every method, connect off, long method, empty URI, fold, cookie
		push_str("GET / HTTP/1.1\r\nHost: x\r\n folded\r\n\r\n");
		push_str("post /a HTTP/0.9\r\n\r\nhead /b HTTP/1.0\r\n\r\nPUT /c HTTP/2.0\r\n\r\n");
		push_str("DELETE /d HTTP/1.1\r\n\r\nTRACE /e HTTP/1.1\r\n\r\n");
		push_str("OPTIONS * HTTP/1.1\r\n\r\nCONNECT h:1 HTTP/1.1\r\n\r\n");
		push_str("GETTINGLONG / HTTP/1.1\r\n\r\nGET  HTTP/1.1\r\n \r\n");
		push_str("GET / HTTP/1000.1\r\nCookie: a=b\r\nX:\t\r\n");
		push_str("\xff\x00~GET / HTTP/9.9999\r\n");
		wait_idle();

		// Extremes of the limits
		write_reg(REG_ALLOW_CONNECT, 1);
		write_reg(REG_METHOD_LIMIT, 1);
		write_reg(REG_NAME_LIMIT, 1);
		write_reg(REG_LONG_LIMIT, 1);
		write_reg(REG_COOKIE_LIMIT, 1);
		write_reg(REG_COUNT_LIMIT, 1);
		write_reg(REG_VERSION_LIMIT, 1);
		for (int i = 0; i < 12; i++) push_str(rnd_request(), i == 6);
		wait_idle();
		write_reg(REG_METHOD_LIMIT, 31);
		write_reg(REG_NAME_LIMIT, 16'hFFFF);
		write_reg(REG_LONG_LIMIT, 16'hFFFF);
		write_reg(REG_COOKIE_LIMIT, 16'hFFFF);
		write_reg(REG_COUNT_LIMIT, 255);
		write_reg(REG_VERSION_LIMIT, 16'hFFFF);
		push_str("CONNECT h:1 HTTP/65535.9\r\nCookie: zz\r\n\r\n");
		push_str({"GET /", rnd_text(70, 8'h21), " HTTP/1.1\r\n\r\n"});
		// receiver holds off long while the sender keeps offering
		hold_req = 1;
		for (int i = 0; i < 8; i++) push_str(rnd_request());
		wait_idle();

		// Mid settings and a noise burst
		write_reg(REG_ALLOW_CONNECT, 0);
		write_reg(REG_METHOD_LIMIT, 5);
		write_reg(REG_NAME_LIMIT, 4);
		write_reg(REG_LONG_LIMIT, 5);
		write_reg(REG_COOKIE_LIMIT, 3);
		write_reg(REG_COUNT_LIMIT, 3);
		write_reg(REG_VERSION_LIMIT, 12);
		for (int i = 0; i < 8; i++) push_str(rnd_request(), i == 4);
		noise = "";
		for (int i = 0; i < 100; i++) noise = {noise, string'(8'($urandom))};
		push_str({noise, "\r\n\r\n"});
		wait_idle();

		write_reg(REG_COOKIE_LIMIT, 16384);
		write_reg(REG_LONG_LIMIT, 4096);
		write_reg(REG_VERSION_LIMIT, 999);
		for (int i = 0; i < 4; i++) push_str(rnd_request());

		while (byte_queue.size() != 0) @(posedge clk);
		while (result_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/hrhp_pkg.sv
rtl/core/http_request_head_parser.sv
verif/http_request_head_parser_tb.sv
